### rtl/core/hng_pkg.sv
`default_nettype none
package hng_pkg;

  localparam int H_W      = 8;
  localparam int GW_W     = 11;
  localparam int GD_W     = 13;
  localparam int CFG_W    = 13;
  localparam int NORM_W   = 16;
  localparam int COL_W    = 10;
  localparam int ROWO_W   = 12;
  localparam int VEC_W    = 11;
  localparam int SQ_W     = 21;
  localparam int SUM_W    = 22;
  localparam int MAG_W    = 15;
  localparam int ROOT_STEPS = 15;

  localparam logic [GW_W-1:0] GW_RESET = 11'd1024;
  localparam logic [GD_W-1:0] GD_RESET = 13'd1024;

  // height-axis component for the four step combinations
  localparam logic signed [VEC_W-1:0] NY_1 = 11'sd255;
  localparam logic signed [VEC_W-1:0] NY_2 = 11'sd510;
  localparam logic signed [VEC_W-1:0] NY_4 = 11'sd1020;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_GRID_WIDTH = 1'b0,
    REG_GRID_DEPTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_DIFF,
    ST_VEC,
    ST_SQ,
    ST_INIT,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic rd0;
    logic rd1;
    logic diff;
    logic vec;
    logic sq;
    logic init;
    logic step;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic act;
    logic emit;
    logic root_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

### rtl/core/hng_ram.sv
`default_nettype none
module hng_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/hng_root.sv
`default_nettype none
module hng_root (
  input  wire logic                      clk,
  input  wire logic                      init,
  input  wire logic                      step,
  input  wire logic [hng_pkg::SUM_W-1:0] s,
  input  wire logic [hng_pkg::SQ_W-1:0]  csq,
  output logic      [hng_pkg::MAG_W-1:0] mag
);
  import hng_pkg::*;

  // Greedy bit search for the largest m with (2m-1)^2*S <= c^2*2^30.
  // p_r = (2m-1)^2*S, a_r = (2m-1)*S*4b, b_r = S*4b^2 for trial bit b.
  logic signed [55:0] p_r, a_r, b_r, lim_r;
  logic [MAG_W-1:0] m_r, bit_r;
  logic signed [55:0] s56, cand;

  assign s56  = {34'b0, s};
  assign cand = p_r + a_r + b_r;
  assign mag  = m_r;

  always_ff @(posedge clk) begin
    if (init) begin
      p_r   <= s56;
      a_r   <= -(s56 <<< 16);
      b_r   <= s56 <<< 30;
      lim_r <= {35'b0, csq} <<< 30;
      m_r   <= '0;
      bit_r <= {1'b1, {(MAG_W-1){1'b0}}};
    end else if (step) begin
      if (cand <= lim_r) begin
        m_r <= m_r | bit_r;
        p_r <= cand;
        a_r <= (a_r >>> 1) + b_r;
      end else begin
        a_r <= a_r >>> 1;
      end
      b_r   <= b_r >>> 2;
      bit_r <= bit_r >> 1;
    end
  end

endmodule
`default_nettype wire

### rtl/core/hng_ctrl.sv
`default_nettype none
module hng_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire hng_pkg::dp_status_t status,
  output logic                     in_stall,
  output hng_pkg::dp_cmd_t         cmd
);
  import hng_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
        if (in_valid && status.act) begin
          state_nxt = ST_RD0;
        end
      end
      ST_RD0: begin
        cmd.rd0   = 1'b1;
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd1   = 1'b1;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = status.emit ? ST_VEC : ST_IDLE;
      end
      ST_VEC: begin
        cmd.vec   = 1'b1;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.step = 1'b1;
        if (status.root_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/hng_dp.sv
`default_nettype none
module hng_dp #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_DEPTH = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [hng_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              in_opcode,
  input  wire logic [hng_pkg::H_W-1:0]           in_height_sample,
  input  wire hng_pkg::dp_cmd_t                  cmd,
  output hng_pkg::dp_status_t                    status,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [hng_pkg::NORM_W-1:0]      out_normal_x,
  output logic signed [hng_pkg::NORM_W-1:0]      out_normal_y,
  output logic signed [hng_pkg::NORM_W-1:0]      out_normal_z,
  output logic        [hng_pkg::COL_W-1:0]       out_column,
  output logic        [hng_pkg::ROWO_W-1:0]      out_row_index,
  output logic                                   out_frame_end
);
  import hng_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_DEPTH + 1);

  // config and frame position
  logic [GW_W-1:0] gw_r;
  logic [GD_W-1:0] gd_r;
  logic [CW-1:0]   col_r;
  logic [RW-1:0]   row_r;
  logic            drain_r;

  logic [31:0]   eff_w, eff_d, gw32, gd32, x_next;
  logic          last, act, emit, is_sample;
  logic [RW-1:0] r_emit, row_inc;

  // per-item context
  logic [CW-1:0]   x_r;
  logic [H_W-1:0]  h_r, c_r, left_r, right_r, down_r, up_r;
  logic            has_up_r, has_left_r, has_right_r, has_down_r, emit_r, fend_r;
  logic [COL_W-1:0]  col_o_r;
  logic [ROWO_W-1:0] row_o_r;

  // arithmetic
  logic signed [VEC_W-1:0] nx_r, ny_r, nz_r;
  logic [SQ_W-1:0]         sqx_r, sqy_r, sqz_r;
  logic [SUM_W-1:0]        s_sum;
  logic [MAG_W-1:0]        mx, my, mz;
  logic [3:0]              it_r;

  // line stores
  logic [CW-1:0]  prev_raddr, rbp_raddr;
  logic [H_W-1:0] prev_q, rbp_q;

  always_comb begin
    gw32 = 32'(gw_r);
    gd32 = 32'(gd_r);
    if (gw32 < 32'd2) eff_w = 32'd2;
    else if (gw32 > 32'(MAX_WIDTH)) eff_w = 32'(MAX_WIDTH);
    else eff_w = gw32;
    if (gd32 < 32'd2) eff_d = 32'd2;
    else if (gd32 > 32'(MAX_DEPTH)) eff_d = 32'(MAX_DEPTH);
    else eff_d = gd32;
  end

  assign is_sample = (in_opcode == OP_SAMPLE);
  assign x_next    = 32'(col_r) + 32'd1;
  assign last      = (x_next >= eff_w);
  assign act       = is_sample ? !drain_r : drain_r;
  assign emit      = !is_sample || (row_r != '0);
  assign r_emit    = (row_r != '0) ? row_r - RW'(1) : '0;
  assign row_inc   = row_r + RW'(1);

  assign status.act       = act;
  assign status.emit      = emit_r;
  assign status.root_last = (it_r == 4'd0);
  assign status.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= GW_RESET;
      gd_r <= GD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH: gw_r <= cfg_data[GW_W-1:0];
        REG_GRID_DEPTH: gd_r <= cfg_data[GD_W-1:0];
        default: ;
      endcase
    end
  end

  // counters advance when an acted-on item is accepted; the item context carries what it needs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= 1'b0;
    end else if (cmd.take && act) begin
      if (is_sample) begin
        if (last) begin
          col_r <= '0;
          row_r <= row_inc;
          if (32'(row_inc) >= eff_d) drain_r <= 1'b1;
        end else begin
          col_r <= col_r + CW'(1);
        end
      end else begin
        if (last) begin
          col_r   <= '0;
          row_r   <= '0;
          drain_r <= 1'b0;
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && act) begin
      x_r         <= col_r;
      h_r         <= in_height_sample;
      has_up_r    <= is_sample;
      emit_r      <= emit;
      has_left_r  <= (col_r != '0);
      has_right_r <= !last;
      has_down_r  <= (r_emit != '0);
      fend_r      <= !is_sample && last;
      col_o_r     <= COL_W'(col_r);
      row_o_r     <= ROWO_W'(r_emit);
    end
    if (cmd.rd1) begin
      c_r    <= prev_q;
      left_r <= has_left_r ? rbp_q : prev_q;
    end
    if (cmd.diff) begin
      right_r <= has_right_r ? prev_q : c_r;
      down_r  <= has_down_r ? rbp_q : c_r;
      up_r    <= has_up_r ? h_r : c_r;
    end
  end

  // first read: center and left, second read: right and down
  assign prev_raddr = cmd.rd0 ? x_r : x_r + CW'(1);
  assign rbp_raddr  = cmd.rd0 ? x_r - CW'(1) : x_r;

  hng_ram #(.WIDTH(H_W), .DEPTH(MAX_WIDTH)) u_prev (
    .clk   (clk),
    .we    (cmd.diff && has_up_r),
    .waddr (x_r),
    .wdata (h_r),
    .raddr (prev_raddr),
    .rdata (prev_q)
  );

  hng_ram #(.WIDTH(H_W), .DEPTH(MAX_WIDTH)) u_rbp (
    .clk   (clk),
    .we    (cmd.diff),
    .waddr (x_r),
    .wdata (c_r),
    .raddr (rbp_raddr),
    .rdata (rbp_q)
  );

  // cross product scaled by 255
  logic signed [8:0]       dx, dz;
  logic signed [VEC_W-1:0] dxe, dze;
  logic                    sx2, sz2;
  logic signed [SUM_W-1:0] px, py, pz;

  assign dx  = $signed({1'b0, right_r}) - $signed({1'b0, left_r});
  assign dz  = $signed({1'b0, up_r}) - $signed({1'b0, down_r});
  assign dxe = {{2{dx[8]}}, dx};
  assign dze = {{2{dz[8]}}, dz};
  assign sx2 = has_left_r && has_right_r;
  assign sz2 = has_down_r && has_up_r;

  always_ff @(posedge clk) begin
    if (cmd.vec) begin
      nx_r <= sz2 ? -(dxe <<< 1) : -dxe;
      nz_r <= sx2 ? -(dze <<< 1) : -dze;
      if (sx2 && sz2) ny_r <= NY_4;
      else if (sx2 || sz2) ny_r <= NY_2;
      else ny_r <= NY_1;
    end
  end

  assign px = nx_r * nx_r;
  assign py = ny_r * ny_r;
  assign pz = nz_r * nz_r;

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      sqx_r <= px[SQ_W-1:0];
      sqy_r <= py[SQ_W-1:0];
      sqz_r <= pz[SQ_W-1:0];
    end
  end

  assign s_sum = {1'b0, sqx_r} + {1'b0, sqy_r} + {1'b0, sqz_r};

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      it_r <= 4'(ROOT_STEPS - 1);
    end else if (cmd.step) begin
      it_r <= it_r - 4'd1;
    end
  end

  hng_root u_root_x (.clk(clk), .init(cmd.init), .step(cmd.step),
                     .s(s_sum), .csq(sqx_r), .mag(mx));
  hng_root u_root_y (.clk(clk), .init(cmd.init), .step(cmd.step),
                     .s(s_sum), .csq(sqy_r), .mag(my));
  hng_root u_root_z (.clk(clk), .init(cmd.init), .step(cmd.step),
                     .s(s_sum), .csq(sqz_r), .mag(mz));

  logic [NORM_W-1:0] magx, magy, magz;
  assign magx = {1'b0, mx};
  assign magy = {1'b0, my};
  assign magz = {1'b0, mz};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_normal_x  <= nx_r[VEC_W-1] ? (~magx + 16'd1) : magx;
      out_normal_y  <= ny_r[VEC_W-1] ? (~magy + 16'd1) : magy;
      out_normal_z  <= nz_r[VEC_W-1] ? (~magz + 16'd1) : magz;
      out_column    <= col_o_r;
      out_row_index <= row_o_r;
      out_frame_end <= fend_r;
    end
  end

endmodule
`default_nettype wire

### rtl/core/heightmap_normal_generator.sv
// Height map to normal map, central differences (one-sided at the edges).
// Input channel: in_valid/in_stall with in_opcode (sample or flush tick) and
// in_height_sample; a transaction completes when in_valid is high and in_stall low.
// Result channel: out_valid/out_stall carries one unit normal in signed Q1.14
// plus column, row_index and frame_end. Results trail the input by one row;
// flush transactions drain the last row, one normal each.
// Work per transaction: an ignored item is taken in the idle state and dropped;
// a first-row sample runs two reads of each line store, then the write-back; an
// item with a result runs the line stores, then difference, squares and root
// setup, the bit-serial root search (one bit of Q1.14 per cycle) and the load of
// the output register. Result appears the cycle after that load.
// A finished result sits in the output register while the next transaction is
// taken; if out_stall holds it, the block waits before the load.
// Reset (rst_n low, synchronous) clears counters, drain flag, handshakes and
// restores grid_width and grid_depth to 1024. Line stores are not cleared.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 width, 1 depth).
`default_nettype none
module heightmap_normal_generator #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_DEPTH = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [hng_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_opcode,
  input  wire logic [hng_pkg::H_W-1:0]           in_height_sample,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [hng_pkg::NORM_W-1:0]      out_normal_x,
  output logic signed [hng_pkg::NORM_W-1:0]      out_normal_y,
  output logic signed [hng_pkg::NORM_W-1:0]      out_normal_z,
  output logic        [hng_pkg::COL_W-1:0]       out_column,
  output logic        [hng_pkg::ROWO_W-1:0]      out_row_index,
  output logic                                   out_frame_end
);
  import hng_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: one transaction at a time through the datapath
  hng_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // line stores, counters, cross product, root search, output register
  hng_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_DEPTH(MAX_DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_opcode        (in_opcode),
    .in_height_sample (in_height_sample),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_normal_x     (out_normal_x),
    .out_normal_y     (out_normal_y),
    .out_normal_z     (out_normal_z),
    .out_column       (out_column),
    .out_row_index    (out_row_index),
    .out_frame_end    (out_frame_end)
  );

`ifndef ASSERT_OFF
  // a transaction that starts work stalls the input in the cycle after it is taken
  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && status.act |=> in_stall)
    else $error("input taken while datapath busy");

  // the height axis always points up
  a_ny_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_normal_y[15] && out_normal_y != 16'sd0)
    else $error("normal_y not positive");

  // the x component of the unit vector stays within one
  a_nx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_x <= 16'sd16384 && out_normal_x >= -16'sd16384)
    else $error("normal_x out of range");
`endif

endmodule
`default_nettype wire

### dv/tb_heightmap_normal_generator.sv
`timescale 1ns / 100ps
module tb_heightmap_normal_generator;
  import hng_pkg::*;

  localparam int LINE_MAX   = 1024;
  localparam int ROWS_MAX   = 4096;
  localparam int STALL_LIMIT = 5000;  // idle cycles before the watchdog fires
  localparam int SETTLE     = 40;     // longer than one result computation

  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic [COL_W-1:0]         col;
    logic [ROWO_W-1:0]        row;
    logic                     last;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic [H_W-1:0] in_height_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [NORM_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic [COL_W-1:0] out_column;
  logic [ROWO_W-1:0] out_row_index;
  logic out_frame_end;

  heightmap_normal_generator DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_height_sample(in_height_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z), .out_column(out_column),
    .out_row_index(out_row_index), .out_frame_end(out_frame_end)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------
  // Shadow of the block: line stores, raster counters, drain flag.
  // ---------------------------------------------------------------
  logic [H_W-1:0] line_prev [LINE_MAX];
  logic [H_W-1:0] line_prev2 [LINE_MAX];
  int unsigned col_cnt, row_cnt;
  bit drain_mode;
  int unsigned width_reg, depth_reg;
  normal_t pending_normals[$];

  int mismatches = 0;
  int idle_cycles = 0;
  bit tx_no_idle = 0, rx_no_idle = 0;
  int rx_gap = 0;
  int rx_hold = 0;   // long receiver hold-off, in cycles

  function automatic int unsigned grid_w();
    return (width_reg < 2) ? 2 : (width_reg > LINE_MAX) ? LINE_MAX : width_reg;
  endfunction

  function automatic int unsigned grid_d();
    return (depth_reg < 2) ? 2 : (depth_reg > ROWS_MAX) ? ROWS_MAX : depth_reg;
  endfunction

  function automatic void enqueue_normal(normal_t n);
    pending_normals = {pending_normals, n};
  endfunction

  // round(16384*|c|/sqrt(s)), ties away from zero, by bisection on exact squares
  function automatic logic [NORM_W-1:0] q14_component(longint c, longint unsigned s);
    longint unsigned mag, rhs, lo, hi, mid, t;
    mag = (c < 0) ? -c : c;
    rhs = (mag * mag) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      if (t * t * s <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (c < 0) lo = -lo;
    return lo[NORM_W-1:0];
  endfunction

  function automatic normal_t surface_normal(int unsigned x, int unsigned r, bit has_up,
                                             int up_val);
    normal_t n;
    int unsigned w;
    int ctr, lft, rgt, dn, up;
    longint sx, sz, vx, vy, vz;
    longint unsigned s;
    w = grid_w();
    ctr = line_prev[x];
    lft = (x > 0) ? line_prev2[x-1] : ctr;
    rgt = (x + 1 < w) ? line_prev[x+1] : ctr;
    dn = (r > 0) ? line_prev2[x] : ctr;
    up = has_up ? up_val : ctr;
    sx = (x > 0 && x + 1 < w) ? 2 : 1;
    sz = (r > 0 && has_up) ? 2 : 1;
    vx = -sz * (rgt - lft);
    vy = 255 * sz * sx;
    vz = -sx * (up - dn);
    s = vx * vx + vy * vy + vz * vz;
    n.nx = q14_component(vx, s);
    n.ny = q14_component(vy, s);
    n.nz = q14_component(vz, s);
    n.col = x[COL_W-1:0];
    n.row = r[ROWO_W-1:0];
    n.last = 1'b0;
    line_prev2[x] = line_prev[x];
    if (has_up) line_prev[x] = up_val[H_W-1:0];
    return n;
  endfunction

  // Advance the shadow by one accepted transaction.
  task automatic predict_normal(opcode_t op, logic [H_W-1:0] h);
    int unsigned x;
    normal_t n;
    x = (col_cnt < LINE_MAX) ? col_cnt : LINE_MAX - 1;
    if (op == OP_SAMPLE) begin
      if (drain_mode) return;
      if (row_cnt == 0) begin
        line_prev2[x] = line_prev[x];
        line_prev[x] = h;
      end else begin
        enqueue_normal(surface_normal(x, row_cnt - 1, 1'b1, h));
      end
      if (x + 1 >= grid_w()) begin
        col_cnt = 0;
        row_cnt++;
        if (row_cnt >= grid_d()) drain_mode = 1;
      end else col_cnt = x + 1;
    end else begin
      if (!drain_mode) return;
      n = surface_normal(x, (row_cnt > 0) ? row_cnt - 1 : 0, 1'b0, 0);
      if (x + 1 >= grid_w()) begin
        n.last = 1'b1;
        col_cnt = 0;
        row_cnt = 0;
        drain_mode = 0;
      end else col_cnt = x + 1;
      enqueue_normal(n);
    end
  endtask

  // ---------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------
  task automatic send_item(opcode_t op, logic [H_W-1:0] h);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_height_sample <= h;
    do @(posedge clk); while (in_stall);
    predict_normal(op, h);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_normals.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Only called between frames, so no store entry is read before it is written.
  task automatic set_grid(int unsigned w, int unsigned d);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data <= w[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_GRID_DEPTH;
    cfg_data <= d[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    width_reg = w & 32'h7FF;
    depth_reg = d & 32'h1FFF;
  endtask

  // One full frame plus its drain; pattern 0 random, 1 checkerboard 0/255.
  // With noise, stray flushes mid-frame and samples during the drain are mixed in.
  task automatic send_frame(int pattern, bit noise);
    int unsigned w, d;
    logic [H_W-1:0] h;
    w = grid_w();
    d = grid_d();
    for (int unsigned r = 0; r < d; r++)
      for (int unsigned x = 0; x < w; x++) begin
        if (noise && $urandom_range(0, 15) == 0) send_item(OP_FLUSH, 8'($urandom()));
        h = (pattern == 1) ? (((x ^ r) & 1) ? 8'hFF : 8'h00) : 8'($urandom());
        send_item(OP_SAMPLE, h);
      end
    for (int unsigned x = 0; x < w; x++) begin
      if (noise && $urandom_range(0, 7) == 0) send_item(OP_SAMPLE, 8'($urandom()));
      send_item(OP_FLUSH, 8'($urandom()));
    end
  endtask

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  task automatic test_early_flush();
    // flush with no frame in progress, then mid-frame: both produce nothing
    send_item(OP_FLUSH, 8'hFF);
    set_grid(3, 3);
    send_item(OP_SAMPLE, 8'h00);
    send_item(OP_FLUSH, 8'h00);
    for (int i = 0; i < 8; i++) send_item(OP_SAMPLE, 8'($urandom()));
    send_item(OP_SAMPLE, 8'hAA);  // ignored while draining
    for (int i = 0; i < 3; i++) send_item(OP_FLUSH, 8'h00);
  endtask

  task automatic test_extreme_heights();
    set_grid(4, 3);
    send_frame(1, 0);
  endtask

  task automatic test_clamped_small();
    set_grid(0, 1);   // clamps to 2 x 2
    send_frame(0, 0);
    set_grid(1, 0);
    send_frame(1, 0);
  endtask

  task automatic test_wide_frame();
    set_grid(100, 2);   // long rows, short frame
    send_frame(0, 0);
  endtask

  task automatic test_deep_frame();
    tx_no_idle = 1;
    set_grid(2, 150);   // many short rows
    send_frame(0, 0);
    tx_no_idle = 0;
  endtask

  task automatic test_backpressure();
    set_grid(6, 5);
    rx_hold = 300;      // receiver blocks while the sender keeps offering
    tx_no_idle = 1;
    send_frame(0, 0);
    tx_no_idle = 0;
    wait_drained();     // sender pauses until every normal is back
    send_frame(0, 1);
  endtask

  task automatic test_random_frames();
    int sent;
    sent = 0;
    while (sent < 420) begin
      set_grid($urandom_range(2, 12), $urandom_range(2, 8));
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      send_frame(0, $urandom_range(0, 2) == 0);
      sent += grid_w() * (grid_d() + 1);
    end
    tx_no_idle = 0;
    rx_no_idle = 0;
  endtask

  // ---------------------------------------------------------------
  // Result side: stall draw at the falling edge, check at the rising edge
  // ---------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap <= rx_gap - 1;
    end else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    normal_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_normal_x, out_normal_y, out_normal_z, out_column, out_row_index,
              out_frame_end};
      rx_gap <= rx_no_idle ? 0 : $urandom_range(0, 8);
      if (pending_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected normal x=%0d y=%0d z=%0d col=%0d row=%0d end=%0b",
                   got.nx, got.ny, got.nz, got.col, got.row, got.last);
      end else begin
        want = pending_normals.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("normal mismatch exp x=%0d y=%0d z=%0d col=%0d row=%0d end=%0b",
                     want.nx, want.ny, want.nz, want.col, want.row, want.last);
            $display("                got x=%0d y=%0d z=%0d col=%0d row=%0d end=%0b",
                     got.nx, got.ny, got.nz, got.col, got.row, got.last);
          end
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    col_cnt = 0;
    row_cnt = 0;
    drain_mode = 0;
    width_reg = GW_RESET;
    depth_reg = GD_RESET;
    for (int i = 0; i < LINE_MAX; i++) begin
      line_prev[i] = '0;
      line_prev2[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_early_flush();
    test_extreme_heights();
    test_clamped_small();
    test_backpressure();
    test_wide_frame();
    test_deep_frame();
    test_random_frames();

    wait_drained();
    if (mismatches == 0 && pending_normals.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/hng_pkg.sv
rtl/core/hng_ram.sv
rtl/core/hng_root.sv
rtl/core/hng_ctrl.sv
rtl/core/hng_dp.sv
rtl/core/heightmap_normal_generator.sv
dv/tb_heightmap_normal_generator.sv
